>>> sv/rdne_pkg.sv
// ----------------------------------------------------------------------------
// rdne_pkg
// Shared types, codes and constants for the reliable datagram endpoint.
// ----------------------------------------------------------------------------
`default_nettype none

package rdne_pkg;

    // Field widths
    localparam int ID_W       = 8;
    localparam int ARG_W      = 32;
    localparam int TYPE_W     = 8;
    localparam int TICK_W     = 16;
    localparam int NACK_W     = 6;
    localparam int TABLE_SIZE = 1 << ID_W;
    localparam int MAX_NACKS  = 63;
    localparam int CFG_AW     = 3;

    // Register reset values
    localparam logic [TICK_W-1:0] TIMEOUT_RESET = 16'd5000;
    localparam logic [TYPE_W-1:0] PING_RESET    = 8'd0;

    // Register indexes (address bit 2)
    localparam logic REG_TIMEOUT = 1'b0;
    localparam logic REG_PING    = 1'b1;

    // Input operations
    localparam logic [1:0] OP_TICK    = 2'd0;
    localparam logic [1:0] OP_CONNECT = 2'd1;
    localparam logic [1:0] OP_SEND    = 2'd2;
    localparam logic [1:0] OP_FRAME   = 2'd3;

    // Result kinds
    localparam logic [1:0] KIND_TX      = 2'd0;
    localparam logic [1:0] KIND_DELIVER = 2'd1;
    localparam logic [1:0] KIND_LOST    = 2'd2;

    // Result sources
    localparam logic [2:0] SRC_SEND    = 3'd0;
    localparam logic [2:0] SRC_NACK    = 3'd1;
    localparam logic [2:0] SRC_RETX    = 3'd2;
    localparam logic [2:0] SRC_PLAIN   = 3'd3;
    localparam logic [2:0] SRC_DELIVER = 3'd4;
    localparam logic [2:0] SRC_LOST    = 3'd5;

    typedef struct packed {
        logic [1:0]        op;
        logic              important;
        logic [TYPE_W-1:0] msg_type;
        logic [ID_W-1:0]   msg_id;
        logic [ARG_W-1:0]  arg_first;
        logic [ARG_W-1:0]  arg_second;
        logic [ARG_W-1:0]  arg_third;
        logic              frame_ok;
    } in_item_t;

    typedef struct packed {
        logic [1:0]        out_kind;
        logic [ID_W-1:0]   out_id;
        logic [TYPE_W-1:0] out_type;
        logic [ARG_W-1:0]  out_arg_first;
        logic [ARG_W-1:0]  out_arg_second;
        logic [ARG_W-1:0]  out_arg_third;
        logic              link_up;
        logic              last;
    } out_item_t;

    typedef struct packed {
        logic [TYPE_W-1:0] msg_type;
        logic [ARG_W-1:0]  arg_first;
        logic [ARG_W-1:0]  arg_second;
        logic [ARG_W-1:0]  arg_third;
    } entry_t;

    typedef struct packed {
        logic       load_item;
        logic       tick_update;
        logic       connect;
        logic       frame_setup;
        logic       nack_finish;
        logic       keepalive;
        logic       mem_read;
        logic       emit;
        logic [2:0] src;
        logic       last;
    } cmd_t;

    typedef struct packed {
        logic [1:0] op;
        logic       frame_ok;
        logic       connected;
        logic       id_nz;
        logic       is_ping;
        logic       arg_nz;
        logic       drop;
        logic       nack_pending;
        logic       out_free;
    } status_t;

endpackage

`default_nettype wire

>>> sv/reliable_datagram_nack_endpoint_unit.sv
// ----------------------------------------------------------------------------
// reliable_datagram_nack_endpoint_unit
// Reliable datagram endpoint with NACK-driven selective retransmission.
// ----------------------------------------------------------------------------
// One item is handled at a time by a sequencer. A tick advances the idle
// count and may drop the link, a connect restarts the link state, a send
// emits one frame and a bad received frame is dropped. A good frame is
// acted on, after a burst of at most 63 NACK pings for its gap when it is
// sequenced and the link is live. The registered read of the 256-entry
// message table for a retransmit is issued in the decision state and is
// ready for the result. Results leave through an output register, so the
// next item is taken while the last result of the previous one still waits.
// A stalled output holds back the sequencer only when it has a further result
// to place, and then for the length of the stall. Table entries never written
// read as zero through per-entry valid bits cleared at reset; no clearing
// pass is needed.
`default_nettype none

module reliable_datagram_nack_endpoint_unit
    import rdne_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire in_item_t          in_data,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output out_item_t              out_data,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [CFG_AW-1:0] paddr,
    input  wire logic [31:0]       pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);

    logic [TICK_W-1:0] timeout_reg;
    logic [TYPE_W-1:0] ping_code_reg;
    logic              cfg_we;
    cmd_t              cmd;
    status_t           st;

    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && pready;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg   <= TIMEOUT_RESET;
            ping_code_reg <= PING_RESET;
        end
        else if (cfg_we)
        begin
            case (paddr[2])
                REG_TIMEOUT: timeout_reg   <= pwdata[TICK_W-1:0];
                default:     ping_code_reg <= pwdata[TYPE_W-1:0];
            endcase
        end
    end

    // Register readback
    always_comb
    begin
        case (paddr[2])
            REG_TIMEOUT: prdata = {{(32-TICK_W){1'b0}}, timeout_reg};
            default:     prdata = {{(32-TYPE_W){1'b0}}, ping_code_reg};
        endcase
    end

    rdne_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .cmd      (cmd),
        .st       (st)
    );

    rdne_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_data       (in_data),
        .cmd           (cmd),
        .st            (st),
        .timeout_ticks (timeout_reg),
        .ping_code     (ping_code_reg),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .out_data      (out_data)
    );

endmodule

`default_nettype wire

>>> sv/rdne_ctrl.sv
// ----------------------------------------------------------------------------
// rdne_ctrl
// Sequencer: decodes each item and steps the datapath through its results.
// ----------------------------------------------------------------------------
`default_nettype none

module rdne_ctrl
    import rdne_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    in_valid,
    output logic         in_stall,
    output cmd_t         cmd,
    input  wire status_t st
);

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_DECODE   = 3'd1;
    localparam logic [2:0] S_TICK_CHK = 3'd2;
    localparam logic [2:0] S_NACK     = 3'd3;
    localparam logic [2:0] S_ACTION   = 3'd4;
    localparam logic [2:0] S_EMIT     = 3'd5;

    logic [2:0] state_reg, state_next;
    logic [2:0] src_reg, src_next;

    // Take items only between items
    assign in_stall = (state_reg != S_IDLE);

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        src_next   = src_reg;
        cmd        = '0;
        cmd.src    = src_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = S_DECODE;
                end
            end
            S_DECODE:
            begin
                case (st.op)
                    OP_TICK:
                    begin
                        cmd.tick_update = 1'b1;
                        state_next      = S_TICK_CHK;
                    end
                    OP_CONNECT:
                    begin
                        cmd.connect = 1'b1;
                        state_next  = S_IDLE;
                    end
                    OP_SEND:
                    begin
                        src_next   = SRC_SEND;
                        state_next = S_EMIT;
                    end
                    default:
                    begin
                        if (!st.frame_ok)
                            state_next = S_IDLE;
                        else if (st.connected && st.id_nz)
                        begin
                            cmd.frame_setup = 1'b1;
                            state_next      = S_NACK;
                        end
                        else
                            state_next = S_ACTION;
                    end
                endcase
            end
            S_TICK_CHK:
            begin
                if (st.drop)
                begin
                    src_next   = SRC_LOST;
                    state_next = S_EMIT;
                end
                else
                    state_next = S_IDLE;
            end
            S_NACK:
            begin
                // One NACK ping per cycle while the output is free
                if (st.nack_pending)
                begin
                    if (st.out_free)
                    begin
                        cmd.emit = 1'b1;
                        cmd.src  = SRC_NACK;
                    end
                end
                else
                begin
                    cmd.nack_finish = 1'b1;
                    state_next      = S_ACTION;
                end
            end
            S_ACTION:
            begin
                if (st.connected && st.is_ping)
                begin
                    if (st.arg_nz)
                    begin
                        cmd.mem_read = 1'b1;
                        src_next     = SRC_RETX;
                        state_next   = S_EMIT;
                    end
                    else if (st.id_nz)
                    begin
                        src_next   = SRC_PLAIN;
                        state_next = S_EMIT;
                    end
                    else
                    begin
                        cmd.keepalive = 1'b1;
                        state_next    = S_IDLE;
                    end
                end
                else
                begin
                    src_next   = SRC_DELIVER;
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (st.out_free)
                begin
                    cmd.emit   = 1'b1;
                    cmd.last   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            src_reg   <= SRC_SEND;
        end
        else
        begin
            state_reg <= state_next;
            src_reg   <= src_next;
        end
    end

    // Results go out only into a free output register
    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> st.out_free)
        else $error("result emitted while output register busy");

    // An accepted item is decoded next
    a_accept_decode: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> (state_reg == S_DECODE))
        else $error("accepted item not decoded");

    // NACK bursts run only for sequenced frames on a live link
    a_nack_link: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_NACK) |-> (st.connected && st.id_nz))
        else $error("NACK burst without live link");

endmodule

`default_nettype wire

>>> sv/rdne_dp.sv
// ----------------------------------------------------------------------------
// rdne_dp
// Datapath: link state, message table, result build and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module rdne_dp
    import rdne_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire in_item_t          in_data,
    input  wire cmd_t              cmd,
    output status_t                st,
    input  wire logic [TICK_W-1:0] timeout_ticks,
    input  wire logic [TYPE_W-1:0] ping_code,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output out_item_t              out_data
);

    in_item_t           item_reg;
    logic               connected_reg, connected_next;
    logic [ID_W-1:0]    next_id_reg, next_id_next;
    logic [ID_W-1:0]    expected_reg, expected_next;
    logic [TICK_W-1:0]  idle_reg, idle_next;
    logic [NACK_W-1:0]  nack_left_reg, nack_left_next;
    out_item_t          out_reg;
    logic               out_valid_reg;

    entry_t             mem [TABLE_SIZE];
    logic [TABLE_SIZE-1:0] valid_reg;
    entry_t             rd_entry_reg;
    logic               rd_valid_reg;

    logic               out_free;
    logic [ID_W-1:0]    gap;
    logic [NACK_W-1:0]  nack_init;
    logic               emit_imp;
    entry_t             emit_entry;
    entry_t             rd_entry;
    logic [ID_W-1:0]    new_id;
    out_item_t          res;
    logic               mem_we;

    assign out_free = !out_valid_reg || !out_stall;

    // Missing ids between the expected id and the frame, capped per frame
    assign gap       = item_reg.msg_id - expected_reg - ID_W'(1);
    assign nack_init = (gap > ID_W'(MAX_NACKS)) ? NACK_W'(MAX_NACKS) : gap[NACK_W-1:0];

    assign new_id   = next_id_reg + ID_W'(1);
    assign rd_entry = rd_valid_reg ? rd_entry_reg : '0;

    // Status to the sequencer
    always_comb
    begin
        st.op           = item_reg.op;
        st.frame_ok     = item_reg.frame_ok;
        st.connected    = connected_reg;
        st.id_nz        = (item_reg.msg_id != '0);
        st.is_ping      = (item_reg.msg_type == ping_code);
        st.arg_nz       = (item_reg.arg_first != '0);
        st.drop         = connected_reg && (idle_reg > timeout_ticks);
        st.nack_pending = (nack_left_reg != '0);
        st.out_free     = out_free;
    end

    // Build the result for the selected source
    always_comb
    begin
        emit_imp   = 1'b0;
        emit_entry = '0;
        res        = '0;
        res.link_up = connected_reg;
        res.last    = cmd.last;
        res.out_kind = KIND_TX;
        case (cmd.src)
            SRC_SEND:
            begin
                emit_imp              = item_reg.important;
                emit_entry.msg_type   = item_reg.msg_type;
                emit_entry.arg_first  = item_reg.arg_first;
                emit_entry.arg_second = item_reg.arg_second;
                emit_entry.arg_third  = item_reg.arg_third;
            end
            SRC_NACK:
            begin
                emit_imp             = 1'b1;
                emit_entry.msg_type  = ping_code;
                emit_entry.arg_first = {{(ARG_W-ID_W){1'b0}}, expected_reg};
            end
            SRC_RETX:
            begin
                emit_imp   = 1'b1;
                emit_entry = rd_entry;
            end
            SRC_PLAIN:
            begin
                emit_entry.msg_type = ping_code;
            end
            SRC_DELIVER:
            begin
                emit_entry.msg_type   = item_reg.msg_type;
                emit_entry.arg_first  = item_reg.arg_first;
                emit_entry.arg_second = item_reg.arg_second;
                emit_entry.arg_third  = item_reg.arg_third;
            end
            default:
            begin
                // link lost: empty frame
            end
        endcase
        res.out_type       = emit_entry.msg_type;
        res.out_arg_first  = emit_entry.arg_first;
        res.out_arg_second = emit_entry.arg_second;
        res.out_arg_third  = emit_entry.arg_third;
        if (cmd.src == SRC_DELIVER)
        begin
            res.out_kind = KIND_DELIVER;
            res.out_id   = item_reg.msg_id;
        end
        else if (cmd.src == SRC_LOST)
        begin
            res.out_kind = KIND_LOST;
            res.link_up  = 1'b0;
        end
        else
            res.out_id = emit_imp ? new_id : '0;
    end

    assign mem_we = cmd.emit && emit_imp;

    // Link state next values
    always_comb
    begin
        connected_next = connected_reg;
        next_id_next   = next_id_reg;
        expected_next  = expected_reg;
        idle_next      = idle_reg;
        nack_left_next = nack_left_reg;
        if (cmd.tick_update && (idle_reg != '1))
            idle_next = idle_reg + TICK_W'(1);
        if (cmd.keepalive)
            idle_next = '0;
        if (cmd.connect)
        begin
            connected_next = 1'b1;
            next_id_next   = '0;
            expected_next  = '0;
            idle_next      = '0;
        end
        if (cmd.frame_setup)
        begin
            expected_next  = expected_reg + ID_W'(1);
            nack_left_next = nack_init;
        end
        if (cmd.nack_finish)
            expected_next = item_reg.msg_id;
        if (mem_we)
            next_id_next = new_id;
        if (cmd.emit && (cmd.src == SRC_NACK))
        begin
            expected_next  = expected_reg + ID_W'(1);
            nack_left_next = nack_left_reg - NACK_W'(1);
        end
        if (cmd.emit && (cmd.src == SRC_LOST))
            connected_next = 1'b0;
    end

    // Hold the accepted item
    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
            item_reg <= in_data;
    end

    // Control and link state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            connected_reg <= 1'b0;
            next_id_reg   <= '0;
            expected_reg  <= '0;
            idle_reg      <= '0;
            nack_left_reg <= '0;
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            connected_reg <= connected_next;
            next_id_reg   <= next_id_next;
            expected_reg  <= expected_next;
            idle_reg      <= idle_next;
            nack_left_reg <= nack_left_next;
            if (mem_we)
                valid_reg[new_id] <= 1'b1;
            if (cmd.emit)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // Message table: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[new_id] <= emit_entry;
        if (cmd.mem_read)
        begin
            rd_entry_reg <= mem[item_reg.arg_first[ID_W-1:0]];
            rd_valid_reg <= valid_reg[item_reg.arg_first[ID_W-1:0]];
        end
    end

    // Output register
    always_ff @(posedge clk)
    begin
        if (cmd.emit)
            out_reg <= res;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // A loaded result is offered in the next cycle
    a_emit_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |=> out_valid_reg)
        else $error("emitted result not offered");

    // Connect restarts the sequence counters
    a_connect_clear: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.connect |=> (connected_reg && (next_id_reg == '0) && (idle_reg == '0)))
        else $error("connect did not restart link state");

    // A link-lost result reports the link down
    a_lost_down: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_reg.out_kind == KIND_LOST)) |-> !out_reg.link_up)
        else $error("link-lost result with link up");

endmodule

`default_nettype wire

>>> bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the reliable datagram NACK endpoint. Items go in
// through the valid/stall channel and are scored against an in-bench copy of
// the endpoint: sequence ids, the message table, NACK bursts, retransmits,
// keepalive pings and the tick timeout. Runs in phases with different
// register settings and idle/stall patterns.
// ----------------------------------------------------------------------------
module testbench
    import rdne_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        in_item_t  stim;
        bit        typed;
        out_item_t want;
    } drill_row_t;

    logic              clk;
    logic              rst_n     = 1'b0;
    logic              in_valid  = 1'b0;
    logic              in_stall;
    in_item_t          in_data   = '0;
    logic              out_valid;
    logic              out_stall = 1'b0;
    out_item_t         out_data;
    logic              psel      = 1'b0;
    logic              penable   = 1'b0;
    logic              pwrite    = 1'b0;
    logic [CFG_AW-1:0] paddr     = '0;
    logic [31:0]       pwdata    = '0;
    logic [31:0]       prdata;
    logic              pready;

    // Endpoint copy: registers and state
    logic [TICK_W-1:0] timeout_cfg;
    logic [TYPE_W-1:0] ping_cfg;
    logic              link_on;
    logic [ID_W-1:0]   tx_seq;
    logic [ID_W-1:0]   rx_seq;
    logic [TICK_W-1:0] quiet_ticks;
    entry_t            msg_store [TABLE_SIZE];

    out_item_t  step_out[$];
    out_item_t  awaited_frames[$];
    drill_row_t drill[$];
    int         mismatch_count = 0;
    int         stall_pct = 0;

    reliable_datagram_nack_endpoint_unit i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_data  (in_data),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_data (out_data),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #20ms;
        $display("TEST FAILED");
        $finish;
    end

    // Stall the result side at the phase's rate
    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(99) < stall_pct);
    end

    task automatic flag_mismatch(string what, logic [31:0] got, logic [31:0] want);
        if (mismatch_count < 100)
            $display("%0t mismatch on %s: got %h, want %h", $realtime, what, got, want);
        mismatch_count++;
    endtask

    // Score each accepted result against the oldest expectation
    task automatic take_result(out_item_t got);
        out_item_t want;
        if (awaited_frames.size() == 0)
        begin
            flag_mismatch("unexpected result", 32'(got.out_type), '0);
            return;
        end
        want = awaited_frames.pop_front();
        if (got.out_kind !== want.out_kind)
            flag_mismatch("out_kind", 32'(got.out_kind), 32'(want.out_kind));
        if (got.out_id !== want.out_id)
            flag_mismatch("out_id", 32'(got.out_id), 32'(want.out_id));
        if (got.out_type !== want.out_type)
            flag_mismatch("out_type", 32'(got.out_type), 32'(want.out_type));
        if (got.out_arg_first !== want.out_arg_first)
            flag_mismatch("out_arg_first", got.out_arg_first, want.out_arg_first);
        if (got.out_arg_second !== want.out_arg_second)
            flag_mismatch("out_arg_second", got.out_arg_second, want.out_arg_second);
        if (got.out_arg_third !== want.out_arg_third)
            flag_mismatch("out_arg_third", got.out_arg_third, want.out_arg_third);
        if (got.link_up !== want.link_up)
            flag_mismatch("link_up", 32'(got.link_up), 32'(want.link_up));
        if (got.last !== want.last)
            flag_mismatch("last", 32'(got.last), 32'(want.last));
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid === 1'b1 && out_stall === 1'b0)
            take_result(out_data);
    end

    function automatic in_item_t item_of(logic [1:0] op, logic imp, logic [7:0] ty,
                                         logic [7:0] id, logic [31:0] a,
                                         logic [31:0] b, logic [31:0] c, logic ok);
        in_item_t it;
        it.op         = op;
        it.important  = imp;
        it.msg_type   = ty;
        it.msg_id     = id;
        it.arg_first  = a;
        it.arg_second = b;
        it.arg_third  = c;
        it.frame_ok   = ok;
        return it;
    endfunction

    function automatic out_item_t frame_of(logic [1:0] kind, logic [7:0] id,
                                           logic [7:0] ty, logic [31:0] a,
                                           logic [31:0] b, logic [31:0] c, logic up);
        out_item_t r;
        r.out_kind       = kind;
        r.out_id         = id;
        r.out_type       = ty;
        r.out_arg_first  = a;
        r.out_arg_second = b;
        r.out_arg_third  = c;
        r.link_up        = up;
        r.last           = 1'b1;
        return r;
    endfunction

    task automatic add_result(logic [1:0] kind, logic [7:0] id, logic [7:0] ty,
                              logic [31:0] a, logic [31:0] b, logic [31:0] c);
        step_out.push_back(frame_of(kind, id, ty, a, b, c, 1'b0));
    endtask

    // Emit a frame; an important one takes the next id and is kept in the table
    task automatic transmit(logic imp, logic [7:0] ty, logic [31:0] a,
                            logic [31:0] b, logic [31:0] c);
        logic [ID_W-1:0] id;
        id = '0;
        if (imp)
        begin
            tx_seq++;
            id = tx_seq;
            msg_store[id] = '{msg_type: ty, arg_first: a, arg_second: b, arg_third: c};
        end
        add_result(KIND_TX, id, ty, a, b, c);
    endtask

    // Advance the endpoint copy by one item and collect its results
    task automatic advance_endpoint(in_item_t it);
        int     nacks;
        entry_t kept;
        step_out.delete();
        case (it.op)
            OP_TICK:
            begin
                if (quiet_ticks != '1)
                    quiet_ticks++;
                if (link_on && quiet_ticks > timeout_cfg)
                begin
                    link_on = 1'b0;
                    add_result(KIND_LOST, '0, '0, '0, '0, '0);
                end
            end
            OP_CONNECT:
            begin
                link_on     = 1'b1;
                tx_seq      = '0;
                rx_seq      = '0;
                quiet_ticks = '0;
            end
            OP_SEND:
                transmit(it.important, it.msg_type, it.arg_first, it.arg_second,
                         it.arg_third);
            default:
            begin
                if (it.frame_ok)
                begin
                    // NACK every skipped id, capped per frame
                    if (link_on && it.msg_id != '0)
                    begin
                        nacks = 0;
                        rx_seq++;
                        while (rx_seq != it.msg_id)
                        begin
                            if (nacks < MAX_NACKS)
                            begin
                                transmit(1'b1, ping_cfg, 32'(rx_seq), '0, '0);
                                nacks++;
                            end
                            rx_seq++;
                        end
                    end
                    if (link_on && it.msg_type == ping_cfg)
                    begin
                        if (it.arg_first != '0)
                        begin
                            kept = msg_store[it.arg_first[ID_W-1:0]];
                            transmit(1'b1, kept.msg_type, kept.arg_first,
                                     kept.arg_second, kept.arg_third);
                        end
                        else if (it.msg_id != '0)
                            transmit(1'b0, ping_cfg, '0, '0, '0);
                        else
                            quiet_ticks = '0;
                    end
                    else
                        add_result(KIND_DELIVER, it.msg_id, it.msg_type, it.arg_first,
                                   it.arg_second, it.arg_third);
                end
            end
        endcase
        foreach (step_out[i])
            step_out[i].link_up = link_on;
        foreach (step_out[i])
            step_out[i].last = (i == step_out.size() - 1);
    endtask

    // Present one item, hold it until taken, then book its expectations
    task automatic feed_item(in_item_t it, int idle_pct, bit typed, out_item_t want);
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
        advance_endpoint(it);
        if (typed)
            awaited_frames.push_back(want);
        else
            foreach (step_out[i])
                awaited_frames.push_back(step_out[i]);
    endtask

    // Write one register over APB and read it back
    task automatic write_register(logic idx, logic [31:0] value);
        logic [31:0] keep;
        keep = (idx == REG_TIMEOUT) ? 32'h0000_FFFF : 32'h0000_00FF;
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if ((prdata & keep) !== (value & keep))
            flag_mismatch("register readback", prdata, value);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (idx == REG_TIMEOUT)
            timeout_cfg = value[TICK_W-1:0];
        else
            ping_cfg = value[TYPE_W-1:0];
    endtask

    // Hold input low, wait out every expected result and any result-free work
    task automatic drain_results();
        in_valid <= 1'b0;
        while (awaited_frames.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
    endtask

    task automatic run_directed(int from, int upto);
        int k;
        for (k = from; k < upto; k++)
            feed_item(drill[k].stim, 0, drill[k].typed, drill[k].want);
    endtask

    // Mostly in-order traffic on a live link, with noise and broken frames
    task automatic draw_item(output in_item_t it);
        int pick;
        int slot;
        pick = $urandom_range(99);
        it.op         = OP_FRAME;
        it.important  = 1'($urandom_range(1));
        it.msg_type   = 8'($urandom);
        it.msg_id     = 8'($urandom);
        it.arg_first  = $urandom;
        it.arg_second = $urandom;
        it.arg_third  = $urandom;
        it.frame_ok   = 1'b1;
        if (pick < 9)
            it.op = OP_TICK;
        else if (pick < 15)
            it.op = OP_CONNECT;
        else if (pick < 37)
        begin
            it.op        = OP_SEND;
            it.important = ($urandom_range(9) < 7);
        end
        else if (pick < 85)
        begin
            slot = $urandom_range(99);
            if (slot < 60)
                it.msg_id = rx_seq + 8'd1;
            else if (slot < 75)
                it.msg_id = rx_seq + 8'($urandom_range(2, 5));
            else
                it.msg_id = '0;
            if ($urandom_range(99) < 45)
            begin
                it.msg_type = ping_cfg;
                slot = $urandom_range(9);
                if (slot < 5)
                    it.arg_first[ID_W-1:0] = tx_seq - 8'($urandom_range(4));
                else if (slot < 8)
                    it.arg_first = '0;
            end
        end
        else if (pick < 94)
            it.frame_ok = 1'b0;
        else if (pick == 99)
        begin
            it.op       = 2'($urandom_range(3));
            it.frame_ok = 1'($urandom_range(1));
        end
    endtask

    task automatic run_random(int count, int idle_pct);
        in_item_t it;
        repeat (count)
        begin
            draw_item(it);
            feed_item(it, idle_pct, 1'b0, '0);
        end
    endtask

    // Directed rows: first block under reset settings, second after reconfig
    task automatic load_drill();
        drill.push_back('{item_of(OP_SEND, 1'b0, 8'h12, 8'h00, 32'hFFFF_FFFF, 32'h0,
                                  32'h8000_0001, 1'b1), 1'b1,
                          frame_of(KIND_TX, 8'h00, 8'h12, 32'hFFFF_FFFF, 32'h0,
                                   32'h8000_0001, 1'b0)});
        drill.push_back('{item_of(OP_SEND, 1'b1, 8'hFF, 8'h00, '0, '0, '0, 1'b1), 1'b1,
                          frame_of(KIND_TX, 8'h01, 8'hFF, '0, '0, '0, 1'b0)});
        drill.push_back('{item_of(OP_SEND, 1'b1, 8'h00, 8'h00, '1, '1, '1, 1'b1), 1'b1,
                          frame_of(KIND_TX, 8'h02, 8'h00, '1, '1, '1, 1'b0)});
        drill.push_back('{item_of(OP_FRAME, 1'b0, 8'h77, 8'h09, 32'hA5A5_A5A5,
                                  32'h5A5A_5A5A, 32'h1, 1'b0), 1'b0, '0});
        drill.push_back('{item_of(OP_FRAME, 1'b0, 8'h00, 8'h05, 32'h1, 32'h2, 32'h3, 1'b1),
                          1'b1, frame_of(KIND_DELIVER, 8'h05, 8'h00, 32'h1, 32'h2,
                                         32'h3, 1'b0)});
        drill.push_back('{item_of(OP_TICK, 1'b0, 8'h00, 8'h00, '0, '0, '0, 1'b1), 1'b0, '0});
        drill.push_back('{item_of(OP_CONNECT, 1'b0, 8'h00, 8'h00, '0, '0, '0, 1'b1),
                          1'b0, '0});
        drill.push_back('{item_of(OP_FRAME, 1'b0, 8'h00, 8'h00, '0, 32'h1234,
                                  32'h5678, 1'b1), 1'b0, '0});
        drill.push_back('{item_of(OP_FRAME, 1'b0, 8'h00, 8'h01, '0, '0, '0, 1'b1), 1'b1,
                          frame_of(KIND_TX, 8'h00, 8'h00, '0, '0, '0, 1'b1)});
        drill.push_back('{item_of(OP_FRAME, 1'b0, 8'h00, 8'h00, 32'h2, '0, '0, 1'b1), 1'b1,
                          frame_of(KIND_TX, 8'h01, 8'h00, '1, '1, '1, 1'b1)});
        drill.push_back('{item_of(OP_FRAME, 1'b1, 8'h00, 8'h00, 32'hFFFF_FF80, '0, '0,
                                  1'b1), 1'b0, '0});
        drill.push_back('{item_of(OP_FRAME, 1'b0, 8'h55, 8'h05, 32'h1111_1111,
                                  32'h2222_2222, 32'h3333_3333, 1'b1), 1'b0, '0});
        drill.push_back('{item_of(OP_FRAME, 1'b0, 8'hAA, 8'h04, 32'h0BAD_F00D,
                                  32'hFFFF_FFFF, 32'h0, 1'b1), 1'b0, '0});
        drill.push_back('{item_of(OP_FRAME, 1'b0, 8'h00, 8'h00, 32'hFFFF_FF01,
                                  32'h7777_7777, 32'h8888_8888, 1'b1), 1'b0, '0});
        drill.push_back('{item_of(OP_SEND, 1'b1, 8'h3C, 8'hC3, 32'hDEAD_BEEF,
                                  32'h0123_4567, 32'h89AB_CDEF, 1'b1), 1'b0, '0});
        drill.push_back('{item_of(OP_FRAME, 1'b0, 8'hFF, 8'hFF, 32'hFFFF_FFFE,
                                  32'h0, 32'h8000_0000, 1'b1), 1'b0, '0});
        drill.push_back('{item_of(OP_FRAME, 1'b1, 8'hFF, 8'hFF, '1, '1, '1, 1'b0), 1'b0, '0});
        drill.push_back('{item_of(OP_FRAME, 1'b0, 8'h21, 8'h00, 32'h4, 32'h5, 32'h6, 1'b1),
                          1'b1, frame_of(KIND_DELIVER, 8'h00, 8'h21, 32'h4, 32'h5,
                                         32'h6, 1'b1)});
        drill.push_back('{item_of(OP_CONNECT, 1'b1, 8'hFF, 8'hFF, '1, '1, '1, 1'b0),
                          1'b0, '0});
        drill.push_back('{item_of(OP_FRAME, 1'b0, 8'h00, 8'h01, '0, '0, '0, 1'b1), 1'b1,
                          frame_of(KIND_TX, 8'h00, 8'h00, '0, '0, '0, 1'b1)});
        drill.push_back('{item_of(OP_TICK, 1'b1, 8'hFF, 8'hFF, '1, '1, '1, 1'b0), 1'b0, '0});
        // Shortest timeout: the second idle tick drops the link
        drill.push_back('{item_of(OP_CONNECT, 1'b0, 8'h00, 8'h00, '0, '0, '0, 1'b1),
                          1'b0, '0});
        drill.push_back('{item_of(OP_TICK, 1'b0, 8'h00, 8'h00, '0, '0, '0, 1'b1), 1'b0, '0});
        drill.push_back('{item_of(OP_TICK, 1'b0, 8'h00, 8'h00, '0, '0, '0, 1'b1), 1'b1,
                          frame_of(KIND_LOST, '0, '0, '0, '0, '0, 1'b0)});
        drill.push_back('{item_of(OP_TICK, 1'b0, 8'h00, 8'h00, '0, '0, '0, 1'b1), 1'b0, '0});
        drill.push_back('{item_of(OP_FRAME, 1'b0, 8'hFF, 8'h00, 32'h5, '0, '0, 1'b1), 1'b1,
                          frame_of(KIND_DELIVER, 8'h00, 8'hFF, 32'h5, '0, '0, 1'b0)});
    endtask

    initial
    begin
        timeout_cfg = TIMEOUT_RESET;
        ping_cfg    = PING_RESET;
        link_on     = 1'b0;
        tx_seq      = '0;
        rx_seq      = '0;
        quiet_ticks = '0;
        foreach (msg_store[k])
            msg_store[k] = '0;
        load_drill();

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Reset settings, no idling
        stall_pct = 0;
        run_directed(0, 21);
        run_random(70, 0);
        drain_results();

        // Shortest timeout, top ping code, sender idling
        write_register(REG_TIMEOUT, 32'd1);
        write_register(REG_PING, 32'hFF);
        run_directed(21, drill.size());
        run_random(90, 46);
        drain_results();

        // Timeout at its ceiling, receiver stalling
        write_register(REG_TIMEOUT, 32'hFFFF);
        write_register(REG_PING, 32'h5A);
        stall_pct = 46;
        feed_item(item_of(OP_CONNECT, 1'b0, 8'h00, 8'h00, '0, '0, '0, 1'b1), 0, 1'b0, '0);
        repeat (4)
            feed_item(item_of(OP_TICK, 1'b0, 8'h00, 8'h00, '0, '0, '0, 1'b1), 0, 1'b0, '0);
        run_random(70, 0);
        drain_results();

        // Short timeout, both sides idling now and then
        write_register(REG_TIMEOUT, 32'd3);
        write_register(REG_PING, 32'h00);
        stall_pct = 7;
        run_random(70, 7);
        drain_results();

        if (mismatch_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
